FILE: src/fringe_pattern_pixel_generator_top_assert.svh
// ----------------------------------------------------------------------------
// Fringe pattern pixel generator assertion macros
// Property wrappers shared by the checker of the top level.
// ----------------------------------------------------------------------------
`ifndef FRINGE_PATTERN_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define FRINGE_PATTERN_PIXEL_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define FPPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fppg check failed");

// next-cycle implication, held off during reset
`define FPPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fppg check failed");

`endif

FILE: src/fppg_pkg.sv
// ----------------------------------------------------------------------------
// Fringe pattern pixel generator package
// Widths, codes, the quarter-wave sine table and its lookup function.
// ----------------------------------------------------------------------------
`default_nettype none

package fppg_pkg;

  localparam int PHASE_BITS  = 16;
  localparam int DIM_BITS    = 13;
  localparam int COORD_BITS  = 12;
  localparam int FRAME_BITS  = 6;
  localparam int COUNT_BITS  = 7;
  localparam int PIXEL_BITS  = 8;

  localparam logic [DIM_BITS-1:0]   MAX_DIMENSION = 13'd4096;
  localparam logic [COUNT_BITS-1:0] MAX_FRAMES    = 7'd64;

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;
  localparam int S_TDATA_BITS  = 32;
  localparam int M_TDATA_BITS  = 8;
  localparam int M_TUSER_BITS  = 1;

  // long division: remainder stays below a divisor of at most 4096
  localparam int REM_BITS     = 12;
  localparam int DIV_NUM_BITS = 34;
  localparam int DIV_STEPS    = 2;
  localparam int DIV_STAGES   = DIV_NUM_BITS / DIV_STEPS;

  // surface offset: numerator of the final division, shift of |s| per period
  localparam int T_BITS     = 22;
  localparam int MAG_W      = 30;
  localparam int OFFS_SHIFT = 30 - PHASE_BITS;

  localparam int TAB_BITS = 10;
  localparam int QTR_BITS = TAB_BITS - 2;
  localparam int QTR_SIZE = 1 << QTR_BITS;
  localparam int SINE_BITS = 16;
  localparam int MAG_BITS  = SINE_BITS - 1;
  localparam logic [TAB_BITS-1:0] QUARTER_IDX = TAB_BITS'(QTR_SIZE);

  // series divisors (2k)(2k+1) as ceil(2^41/d), exact for terms below 2^33
  localparam int SER_SHIFT = 41;
  localparam longint unsigned SER_RECIP [6] = '{
    ((64'd1 << SER_SHIFT) + 64'd5) / 64'd6,
    ((64'd1 << SER_SHIFT) + 64'd19) / 64'd20,
    ((64'd1 << SER_SHIFT) + 64'd41) / 64'd42,
    ((64'd1 << SER_SHIFT) + 64'd71) / 64'd72,
    ((64'd1 << SER_SHIFT) + 64'd109) / 64'd110,
    ((64'd1 << SER_SHIFT) + 64'd155) / 64'd156
  };

  localparam int PIX_SUM_BITS = 25;
  localparam logic signed [PIX_SUM_BITS-1:0] PIX_BIAS = 25'sd4210688;
  localparam logic signed [7:0] PIX_GAIN = 8'sd90;

  typedef enum logic [1:0] {
    PER_1  = 2'd0,
    PER_8  = 2'd1,
    PER_64 = 2'd2
  } period_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COUNT  = 2'd2,
    REG_OPEN   = 2'd3
  } reg_e;

  typedef struct packed {
    logic [REM_BITS-1:0]     rem;
    logic [DIV_NUM_BITS-1:0] num;
    logic [PHASE_BITS-1:0]   quo;
  } div_st_t;

  typedef logic [MAG_BITS-1:0] qsine_tab_t [QTR_SIZE];

  // first quadrant of the sine, Q0.15 magnitude, seven-term series in Q30
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t       tab;
    longint unsigned  a;
    longint unsigned  a2;
    longint unsigned  term;
    longint           sum;
    longint           r;
    logic [127:0]     prod;
    for (int u = 0; u < QTR_SIZE; u++) begin
      a    = (64'd6746518852 * longint'(u)) >> TAB_BITS;
      a2   = (a * a) >> 30;
      term = a;
      sum  = longint'(a);
      for (int k = 1; k <= 6; k++) begin
        prod = 128'((term * a2) >> 30) * 128'(SER_RECIP[k-1]);
        term = 64'(prod >> SER_SHIFT);
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 16384) >>> 15;
      if (r > 32767) begin
        r = 32767;
      end
      tab[u] = MAG_BITS'(r);
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

  function automatic logic signed [SINE_BITS-1:0] sine_lookup(
    input logic [TAB_BITS-1:0] idx
  );
    logic [1:0]          quad;
    logic [QTR_BITS-1:0] off;
    logic [QTR_BITS-1:0] addr;
    logic [MAG_BITS-1:0] mag;
    quad = idx[TAB_BITS-1 -: 2];
    off  = idx[QTR_BITS-1:0];
    addr = quad[0] ? QTR_BITS'(QTR_SIZE - int'(off)) : off;
    mag  = (quad[0] && off == '0) ? '1 : QSINE[addr];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

`default_nettype wire

FILE: src/fppg_divider.sv
// ----------------------------------------------------------------------------
// Fringe pattern pixel generator divider
// Pipelined restoring divider, two quotient bits per stage, low phase bits out.
// ----------------------------------------------------------------------------
`default_nettype none

module fppg_divider
  import fppg_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [DIV_NUM_BITS-1:0] num_i,
  input  logic [DIM_BITS-1:0]     den_i,
  output logic [PHASE_BITS-1:0]   quo_o
);

  div_st_t st_q [DIV_STAGES];
  div_st_t st_d [DIV_STAGES];
  div_st_t first_st;

  function automatic div_st_t div_stage(input div_st_t st, input logic [DIM_BITS-1:0] den);
    div_st_t           nx;
    logic [REM_BITS:0] trial;
    nx = st;
    for (int j = 0; j < DIV_STEPS; j++) begin
      trial  = {nx.rem, nx.num[DIV_NUM_BITS-1]};
      nx.num = nx.num << 1;
      if (trial >= den) begin
        nx.rem = REM_BITS'(trial - den);
        nx.quo = {nx.quo[PHASE_BITS-2:0], 1'b1};
      end else begin
        nx.rem = trial[REM_BITS-1:0];
        nx.quo = {nx.quo[PHASE_BITS-2:0], 1'b0};
      end
    end
    return nx;
  endfunction

  always_comb begin
    first_st.rem = '0;
    first_st.num = num_i;
    first_st.quo = '0;
    st_d[0] = div_stage(first_st, den_i);
    for (int s = 1; s < DIV_STAGES; s++) begin
      st_d[s] = div_stage(st_q[s-1], den_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign quo_o = st_q[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

FILE: src/fringe_pattern_pixel_generator_top.sv
// Four-step phase-shifted fringe pattern generator. Send one word per pixel
// (column, row, frame index) and get back the 8-bit gray value, or an error
// flag with value 0 when capture is closed or the frame index is not below the
// frame count. One pixel is taken every cycle while ready is high; each word
// passes through the input register, two 17-stage long dividers (fringe and
// surface angles, then the surface phase offset), the table, multiplier,
// offset and cosine stages and the output register. An output register plus one
// skid entry keep input ready while a result waits; ready drops only once both
// hold an untaken result. Write the APB registers only while no pixel is in
// flight.
// ----------------------------------------------------------------------------
// Fringe pattern pixel generator top level
// Config registers, pixel pipeline, output register with skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fringe_pattern_pixel_generator_top
  import fppg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // column [11:0], row [23:12], frame_index [29:24], zero [31:30]
  input  logic [S_TDATA_BITS-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // pixel_value [7:0]
  output logic [M_TDATA_BITS-1:0]  m_axis_tdata,
  // request_error [0]
  output logic [M_TUSER_BITS-1:0]  m_axis_tuser
);

  typedef struct packed {
    logic       err;
    period_e    per;
    logic [1:0] step;
  } side_a_t;

  typedef struct packed {
    logic                  err;
    logic                  neg;
    logic [PHASE_BITS-1:0] base;
  } side_b_t;

  // configuration
  logic [DIM_BITS-1:0]   width_q;
  logic [DIM_BITS-1:0]   height_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  open_q;
  logic                  cfg_we;
  logic [DIM_BITS-1:0]   w_eff;
  logic [DIM_BITS-1:0]   h_eff;
  logic [COUNT_BITS-1:0] count_eff;
  reg_e                  cfg_sel;

  // pipeline
  logic                     adv;
  logic                     in_valid_q;
  logic [COORD_BITS-1:0]    in_x_q;
  logic [COORD_BITS-1:0]    in_y_q;
  logic [FRAME_BITS-1:0]    in_fi_q;
  side_a_t                  side0;
  logic [COORD_BITS+5:0]    xs;
  logic [DIV_NUM_BITS-1:0]  num_x;
  logic [DIV_NUM_BITS-1:0]  num_y;
  logic [DIV_NUM_BITS-1:0]  num_p;
  logic [PHASE_BITS-1:0]    sx_quo;
  logic [PHASE_BITS-1:0]    cy_quo;
  logic [PHASE_BITS-1:0]    proj_quo;
  logic                     val_a_q [DIV_STAGES];
  side_a_t                  side_a_q [DIV_STAGES];

  logic                          p1_valid_q;
  side_a_t                       p1_side_q;
  logic signed [SINE_BITS-1:0]   p1_sin_q;
  logic signed [SINE_BITS-1:0]   p1_cos_q;
  logic [PHASE_BITS-1:0]         p1_proj_q;

  logic                          p2_valid_q;
  side_a_t                       p2_side_q;
  logic signed [2*SINE_BITS-1:0] p2_prod_q;
  logic [PHASE_BITS-1:0]         p2_proj_q;

  logic [2*SINE_BITS-1:0] abs_prod;
  logic [MAG_W-1:0]       mag;
  logic [T_BITS-1:0]      tshift;
  logic [T_BITS:0]        tsum;
  side_b_t                side3;

  logic                  p3_valid_q;
  side_b_t               p3_side_q;
  logic [T_BITS-1:0]     p3_t_q;
  logic [PHASE_BITS-1:0] q_quo;
  logic                  val_b_q [DIV_STAGES];
  side_b_t               side_b_q [DIV_STAGES];

  logic [PHASE_BITS-1:0]       phase;
  logic                        p4_valid_q;
  logic                        p4_err_q;
  logic signed [SINE_BITS-1:0] p4_cos_q;

  logic signed [PIX_SUM_BITS-1:0] pix_sum;
  logic [PIXEL_BITS-1:0]          new_pix;

  // output register and skid entry
  logic                  out_valid_q, out_valid_d;
  logic [PIXEL_BITS-1:0] out_pix_q;
  logic                  out_err_q;
  logic                  skid_valid_q, skid_valid_d;
  logic [PIXEL_BITS-1:0] skid_pix_q;
  logic                  skid_err_q;
  logic                  load_out;
  logic                  load_skid;
  logic                  from_skid;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_sel = reg_e'(paddr[APB_ADDR_BITS-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      count_q  <= 7'd12;
      open_q   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_WIDTH:  width_q  <= pwdata[DIM_BITS-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_BITS-1:0];
        REG_COUNT:  count_q  <= pwdata[COUNT_BITS-1:0];
        REG_OPEN:   open_q   <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH:  prdata = APB_DATA_BITS'(width_q);
      REG_HEIGHT: prdata = APB_DATA_BITS'(height_q);
      REG_COUNT:  prdata = APB_DATA_BITS'(count_q);
      REG_OPEN:   prdata = APB_DATA_BITS'(open_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_BITS'(1);
    end else if (width_q > MAX_DIMENSION) begin
      w_eff = MAX_DIMENSION;
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_BITS'(1);
    end else if (height_q > MAX_DIMENSION) begin
      h_eff = MAX_DIMENSION;
    end else begin
      h_eff = height_q;
    end
    count_eff = (count_q > MAX_FRAMES) ? MAX_FRAMES : count_q;
  end

  // ---------------- input stage ----------------
  assign adv           = !skid_valid_q;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_x_q  <= s_axis_tdata[COORD_BITS-1:0];
      in_y_q  <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      in_fi_q <= s_axis_tdata[2*COORD_BITS+FRAME_BITS-1:2*COORD_BITS];
    end
  end

  always_comb begin
    side0.err  = !open_q || ({1'b0, in_fi_q} >= count_eff);
    side0.step = in_fi_q[1:0];
    unique case (in_fi_q[FRAME_BITS-1:2])
      4'd0:    side0.per = PER_1;
      4'd1:    side0.per = PER_8;
      default: side0.per = PER_64;
    endcase
    unique case (side0.per)
      PER_1:   xs = {6'b0, in_x_q};
      PER_8:   xs = {3'b0, in_x_q, 3'b0};
      PER_64:  xs = {in_x_q, 6'b0};
      default: xs = {6'b0, in_x_q};
    endcase
  end

  assign num_x = DIV_NUM_BITS'({in_x_q, {(PHASE_BITS+1){1'b0}}});
  assign num_y = DIV_NUM_BITS'({in_y_q, {(PHASE_BITS+1){1'b0}}});
  assign num_p = DIV_NUM_BITS'({xs, {PHASE_BITS{1'b0}}});

  fppg_divider u_div_sx (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_x),
    .den_i (w_eff),
    .quo_o (sx_quo)
  );

  fppg_divider u_div_cy (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_y),
    .den_i (h_eff),
    .quo_o (cy_quo)
  );

  fppg_divider u_div_proj (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_p),
    .den_i (w_eff),
    .quo_o (proj_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        val_a_q[s] <= 1'b0;
      end
    end else if (adv) begin
      val_a_q[0] <= in_valid_q;
      for (int s = 1; s < DIV_STAGES; s++) begin
        val_a_q[s] <= val_a_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_a_q[0] <= side0;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_a_q[s] <= side_a_q[s-1];
      end
    end
  end

  // ---------------- table, multiply, offset stages ----------------
  always_comb begin
    abs_prod = p2_prod_q[2*SINE_BITS-1] ? 32'(-p2_prod_q) : 32'(p2_prod_q);
    mag      = abs_prod[MAG_W-1:0];
    unique case (p2_side_q.per)
      PER_1:   tshift = T_BITS'(mag >> OFFS_SHIFT);
      PER_8:   tshift = T_BITS'(mag >> (OFFS_SHIFT - 3));
      PER_64:  tshift = T_BITS'(mag >> (OFFS_SHIFT - 6));
      default: tshift = T_BITS'(mag >> OFFS_SHIFT);
    endcase
    tsum       = (T_BITS+1)'(tshift) + (T_BITS+1)'(w_eff);
    side3.err  = p2_side_q.err;
    side3.neg  = p2_prod_q[2*SINE_BITS-1];
    side3.base = p2_proj_q + {p2_side_q.step, {(PHASE_BITS-2){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
    end else if (adv) begin
      p1_valid_q <= val_a_q[DIV_STAGES-1];
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_side_q <= side_a_q[DIV_STAGES-1];
      p1_sin_q  <= sine_lookup(sx_quo[PHASE_BITS-1 -: TAB_BITS]);
      p1_cos_q  <= sine_lookup(TAB_BITS'(cy_quo[PHASE_BITS-1 -: TAB_BITS] + QUARTER_IDX));
      p1_proj_q <= proj_quo;
      p2_side_q <= p1_side_q;
      p2_prod_q <= p1_sin_q * p1_cos_q;
      p2_proj_q <= p1_proj_q;
      p3_side_q <= side3;
      p3_t_q    <= tsum[T_BITS:1];
    end
  end

  fppg_divider u_div_offs (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (DIV_NUM_BITS'(p3_t_q)),
    .den_i (w_eff),
    .quo_o (q_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        val_b_q[s] <= 1'b0;
      end
    end else if (adv) begin
      val_b_q[0] <= p3_valid_q;
      for (int s = 1; s < DIV_STAGES; s++) begin
        val_b_q[s] <= val_b_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_b_q[0] <= p3_side_q;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_b_q[s] <= side_b_q[s-1];
      end
    end
  end

  // ---------------- phase and cosine ----------------
  assign phase = side_b_q[DIV_STAGES-1].neg ? side_b_q[DIV_STAGES-1].base + q_quo
                                             : side_b_q[DIV_STAGES-1].base - q_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_valid_q <= 1'b0;
    end else if (adv) begin
      p4_valid_q <= val_b_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_err_q <= side_b_q[DIV_STAGES-1].err;
      p4_cos_q <= sine_lookup(TAB_BITS'(phase[PHASE_BITS-1 -: TAB_BITS] + QUARTER_IDX));
    end
  end

  assign pix_sum = PIX_BIAS + PIX_GAIN * PIX_SUM_BITS'(p4_cos_q);
  assign new_pix = p4_err_q ? '0 : pix_sum[SINE_BITS+PIXEL_BITS-2:SINE_BITS-1];

  // ---------------- output register and skid ----------------
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    from_skid    = 1'b0;
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        skid_valid_d = 1'b0;
        from_skid    = 1'b1;
      end
    end else if (p4_valid_q) begin
      if (!out_valid_q || m_axis_tready) begin
        out_valid_d = 1'b1;
        load_out    = 1'b1;
      end else begin
        skid_valid_d = 1'b1;
        load_skid    = 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pix_q <= new_pix;
      out_err_q <= p4_err_q;
    end else if (from_skid) begin
      out_pix_q <= skid_pix_q;
      out_err_q <= skid_err_q;
    end
    if (load_skid) begin
      skid_pix_q <= new_pix;
      skid_err_q <= p4_err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tuser  = out_err_q;

endmodule

`default_nettype wire

FILE: src/fppg_checker.sv
// ----------------------------------------------------------------------------
// Fringe pattern pixel generator checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fringe_pattern_pixel_generator_top_assert.svh"

module fppg_checker
  import fppg_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tready,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [M_TDATA_BITS-1:0] m_axis_tdata,
  input logic [M_TUSER_BITS-1:0] m_axis_tuser
);

  localparam logic [M_TDATA_BITS-1:0] PIX_MIN = 8'd38;
  localparam logic [M_TDATA_BITS-1:0] PIX_MAX = 8'd218;

  `FPPG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `FPPG_ASSERT_SAME(a_err_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
  `FPPG_ASSERT_SAME(a_pix_range, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata >= PIX_MIN && m_axis_tdata <= PIX_MAX)
  `FPPG_ASSERT_SAME(a_stall_full, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid)

endmodule

bind fringe_pattern_pixel_generator_top fppg_checker u_fppg_checker (.*);

`default_nettype wire
